// ===== rtl/ptfm_pkg.sv =====
// ----------------------------------------------------------------------------
// ptfm_pkg: shared types and constants of the period to flow meter
// Widths, register map, reset values and state encodings.
// ----------------------------------------------------------------------------
package ptfm_pkg;

  // counter widths
  localparam int TIMER_BITS = 16;
  localparam int COUNT_BITS = 32;

  // field widths
  localparam int INTERVAL_W = 16;
  localparam int CLK_W      = 40;
  localparam int GAIN_W     = 24;
  localparam int RES_W      = 32;
  localparam int PROD_W     = GAIN_W + RES_W;
  localparam int FRAC_BITS  = 16;

  // configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 64;
  localparam logic [1:0] REG_REPORT_INTERVAL = 2'd0;
  localparam logic [1:0] REG_CLOCK_MHZ       = 2'd1;
  localparam logic [1:0] REG_FLOW_GAIN       = 2'd2;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 16'd244;
  localparam logic [CLK_W-1:0]      CLOCK_RST    = 40'd16000000000;
  localparam logic [GAIN_W-1:0]     GAIN_RST     = 24'd400359;

  // job queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // divider step counter
  localparam int STEP_W = $clog2(CLK_W + 1);

  typedef enum logic [1:0] {
    PH_WAITING   = 2'd0,
    PH_COUNTING  = 2'd1,
    PH_COMPUTING = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    B_IDLE = 3'd0,
    B_DIV  = 3'd1,
    B_MUL  = 3'd2,
    B_FIN  = 3'd3,
    B_OUT  = 3'd4
  } back_state_t;

  // one measured period handed from front to back
  typedef struct packed {
    logic [COUNT_BITS-1:0] period;
    logic                  report;
  } job_t;

endpackage

// ===== rtl/ptfm_queue.sv =====
// ----------------------------------------------------------------------------
// ptfm_queue: short job queue between front and back
// Flop-based FIFO of measured periods; lets each side stall on its own.
// ----------------------------------------------------------------------------
module ptfm_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ptfm_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output ptfm_pkg::job_t pop_job,
  output logic           empty
);

  ptfm_pkg::job_t                mem_r [ptfm_pkg::QUEUE_DEPTH];
  logic [ptfm_pkg::QPTR_W-1:0]   wr_ptr_r;
  logic [ptfm_pkg::QPTR_W-1:0]   rd_ptr_r;
  logic [ptfm_pkg::QPTR_W:0]     cnt_r;
  logic                          do_push;
  logic                          do_pop;

  assign full    = (cnt_r == (ptfm_pkg::QPTR_W+1)'(ptfm_pkg::QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = mem_r[rd_ptr_r];

  // store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/ptfm_front.sv =====
// ----------------------------------------------------------------------------
// ptfm_front: per-cycle counter, report counter and edge sequencer
// Takes one word per counting cycle and queues a job for each measured period.
// ----------------------------------------------------------------------------
module ptfm_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic                              edge_req,
  input  logic [ptfm_pkg::INTERVAL_W-1:0]   report_interval,
  input  logic                              q_full,
  output logic                              push,
  output ptfm_pkg::job_t                    push_job
);

  ptfm_pkg::phase_t                  phase_r, phase_nxt;
  logic [ptfm_pkg::COUNT_BITS-1:0]   cycle_r, cycle_nxt;
  logic [ptfm_pkg::INTERVAL_W-1:0]   rc_r, rc_nxt;
  logic [ptfm_pkg::COUNT_BITS-1:0]   period_r, period_nxt;
  logic [ptfm_pkg::COUNT_BITS-1:0]   cnt_inc;
  logic [ptfm_pkg::INTERVAL_W-1:0]   rc_inc;
  logic                              wrapped;
  logic                              report_now;
  logic                              acc;

  // stall only when a result must be queued and the queue is full
  assign in_tready = !((phase_r == ptfm_pkg::PH_COMPUTING) && q_full);
  assign acc       = in_tvalid && in_tready;

  assign cnt_inc    = cycle_r + 1'b1;
  assign wrapped    = (cnt_inc[ptfm_pkg::TIMER_BITS-1:0] == '0);
  assign rc_inc     = (wrapped && (rc_r < report_interval)) ? rc_r + 1'b1 : rc_r;
  assign report_now = (rc_inc >= report_interval);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (acc) begin
      case (phase_r)
        ptfm_pkg::PH_WAITING: begin
          if (edge_req) phase_nxt = ptfm_pkg::PH_COUNTING;
        end
        ptfm_pkg::PH_COUNTING: begin
          if (edge_req) phase_nxt = ptfm_pkg::PH_COMPUTING;
        end
        ptfm_pkg::PH_COMPUTING: phase_nxt = ptfm_pkg::PH_WAITING;
        default: phase_nxt = ptfm_pkg::PH_WAITING;
      endcase
    end
  end

  // counter updates and job push
  always_comb begin
    cycle_nxt       = cycle_r;
    rc_nxt          = rc_r;
    period_nxt      = period_r;
    push            = 1'b0;
    push_job.period = period_r;
    push_job.report = report_now;
    if (acc) begin
      case (phase_r)
        ptfm_pkg::PH_COMPUTING: begin
          cycle_nxt = cnt_inc;
          rc_nxt    = report_now ? '0 : rc_inc;
          push      = 1'b1;
        end
        ptfm_pkg::PH_WAITING: begin
          if (edge_req) begin
            cycle_nxt = '0;
          end else begin
            cycle_nxt = cnt_inc;
            rc_nxt    = rc_inc;
          end
        end
        ptfm_pkg::PH_COUNTING: begin
          cycle_nxt = cnt_inc;
          rc_nxt    = rc_inc;
          if (edge_req) period_nxt = cnt_inc;
        end
        default: begin
          cycle_nxt = cnt_inc;
          rc_nxt    = rc_inc;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= ptfm_pkg::PH_WAITING;
      cycle_r  <= '0;
      rc_r     <= '0;
      period_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      cycle_r  <= cycle_nxt;
      rc_r     <= rc_nxt;
      period_r <= period_nxt;
    end
  end

endmodule

// ===== rtl/ptfm_back.sv =====
// ----------------------------------------------------------------------------
// ptfm_back: reciprocal and flow scaling of one queued period
// Restoring divider, one quotient bit a cycle, then one multiply and output.
// ----------------------------------------------------------------------------
module ptfm_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ptfm_pkg::job_t                  job,
  input  logic                            q_empty,
  output logic                            pop,
  input  logic [ptfm_pkg::CLK_W-1:0]      clock_mhz,
  input  logic [ptfm_pkg::GAIN_W-1:0]     flow_gain,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ptfm_pkg::RES_W-1:0]      out_period,
  output logic [ptfm_pkg::RES_W-1:0]      out_freq,
  output logic [ptfm_pkg::RES_W-1:0]      out_flow,
  output logic                            out_report,
  output logic                            out_sat
);

  localparam int CB = ptfm_pkg::COUNT_BITS;
  localparam int CW = ptfm_pkg::CLK_W;
  localparam int RW = ptfm_pkg::RES_W;
  localparam int PW = ptfm_pkg::PROD_W;

  ptfm_pkg::back_state_t          state_r, state_nxt;
  logic [CB-1:0]                  div_r;
  logic [CB-1:0]                  rem_r;
  logic [CW-1:0]                  quo_r;
  logic [ptfm_pkg::STEP_W-1:0]    step_r;
  logic                           report_r;
  logic                           sat_r;
  logic [RW-1:0]                  per_r;
  logic [RW-1:0]                  freq_r;
  logic [PW-1:0]                  prod_r;
  logic [RW-1:0]                  per_o_r, freq_o_r, flow_o_r;
  logic                           report_o_r, sat_o_r;

  logic [CB:0]                    rem_sh;
  logic [CB+1:0]                  diff;
  logic                           ge;
  logic                           last_step;
  logic [63:0]                    per64;
  logic                           per_sat;
  logic                           quo_sat;
  logic [RW-1:0]                  freq_c;
  logic [PW-1:0]                  prod_c;
  logic                           flow_sat;
  logic                           div_step, mul_en, fin_en;

  // one restoring step
  assign rem_sh    = {rem_r, quo_r[CW-1]};
  assign diff      = {1'b0, rem_sh} - {2'b00, div_r};
  assign ge        = !diff[CB+1];
  assign last_step = (step_r == ptfm_pkg::STEP_W'(CW - 1));

  // period clipped to the result width
  assign per64   = 64'(job.period);
  assign per_sat = |per64[63:RW];

  // clip quotient, scale by gain
  assign quo_sat  = |quo_r[CW-1:RW];
  assign freq_c   = quo_sat ? '1 : quo_r[RW-1:0];
  assign prod_c   = PW'(flow_gain) * PW'(freq_c);
  assign flow_sat = |prod_r[PW-1:RW+ptfm_pkg::FRAC_BITS];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ptfm_pkg::B_IDLE: if (!q_empty)  state_nxt = ptfm_pkg::B_DIV;
      ptfm_pkg::B_DIV:  if (last_step) state_nxt = ptfm_pkg::B_MUL;
      ptfm_pkg::B_MUL:  state_nxt = ptfm_pkg::B_FIN;
      ptfm_pkg::B_FIN:  state_nxt = ptfm_pkg::B_OUT;
      ptfm_pkg::B_OUT:  if (out_tready) state_nxt = ptfm_pkg::B_IDLE;
      default:          state_nxt = ptfm_pkg::B_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    pop        = 1'b0;
    div_step   = 1'b0;
    mul_en     = 1'b0;
    fin_en     = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      ptfm_pkg::B_IDLE: pop        = !q_empty;
      ptfm_pkg::B_DIV:  div_step   = 1'b1;
      ptfm_pkg::B_MUL:  mul_en     = 1'b1;
      ptfm_pkg::B_FIN:  fin_en     = 1'b1;
      ptfm_pkg::B_OUT:  out_tvalid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ptfm_pkg::B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath: load job, divide, multiply, hold result
  always_ff @(posedge clk) begin
    if (pop) begin
      div_r    <= job.period;
      rem_r    <= '0;
      quo_r    <= clock_mhz;
      step_r   <= '0;
      report_r <= job.report;
      sat_r    <= per_sat;
      per_r    <= per_sat ? '1 : per64[RW-1:0];
    end
    if (div_step) begin
      rem_r  <= ge ? diff[CB-1:0] : rem_sh[CB-1:0];
      quo_r  <= {quo_r[CW-2:0], ge};
      step_r <= step_r + 1'b1;
    end
    if (mul_en) begin
      freq_r <= freq_c;
      prod_r <= prod_c;
      sat_r  <= sat_r | quo_sat;
    end
    if (fin_en) begin
      per_o_r    <= per_r;
      freq_o_r   <= freq_r;
      flow_o_r   <= flow_sat ? '1 : prod_r[RW+ptfm_pkg::FRAC_BITS-1:ptfm_pkg::FRAC_BITS];
      report_o_r <= report_r;
      sat_o_r    <= sat_r | flow_sat;
    end
  end

  assign out_period = per_o_r;
  assign out_freq   = freq_o_r;
  assign out_flow   = flow_o_r;
  assign out_report = report_o_r;
  assign out_sat    = sat_o_r;

endmodule

// ===== rtl/period_to_flow_meter.sv =====
// ----------------------------------------------------------------------------
// period_to_flow_meter: reciprocal-period frequency counter with flow output
// Path: the word that follows the closing edge queues a job; the back end pops
//   it, runs the 40-step restoring divider, multiplies and registers the result.
// Throughput: one word per cycle unless stalled; the back end takes one job at
//   a time, the four-entry queue absorbs bursts, input stalls only when full.
// Reset (rst_n low, synchronous): counters and queue clear, registers load
//   their defaults; no clearing pass.
// ----------------------------------------------------------------------------
module period_to_flow_meter (
  input  logic                               clk,
  input  logic                               rst_n,
  // input word
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,   // [0] edge_req
  // result word
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [95:0]                        out_tdata,  // [31:0] period_cycles,
                                                         // [63:32] frequency_mhz,
                                                         // [95:64] flow_milli_gph
  output logic [1:0]                         out_tuser,  // [0] report, [1] saturated
  // configuration
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [ptfm_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [ptfm_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [ptfm_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready
);

  logic [ptfm_pkg::INTERVAL_W-1:0] interval_r;
  logic [ptfm_pkg::CLK_W-1:0]      clock_r;
  logic [ptfm_pkg::GAIN_W-1:0]     gain_r;
  logic                            cfg_wr;
  logic [1:0]                      cfg_idx;

  logic           q_push, q_full, q_pop, q_empty;
  ptfm_pkg::job_t push_job, pop_job;

  logic [ptfm_pkg::RES_W-1:0] res_period, res_freq, res_flow;
  logic                       res_report, res_sat;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[4:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= ptfm_pkg::INTERVAL_RST;
      clock_r    <= ptfm_pkg::CLOCK_RST;
      gain_r     <= ptfm_pkg::GAIN_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        ptfm_pkg::REG_REPORT_INTERVAL: interval_r <= cfg_pwdata[ptfm_pkg::INTERVAL_W-1:0];
        ptfm_pkg::REG_CLOCK_MHZ:       clock_r    <= cfg_pwdata[ptfm_pkg::CLK_W-1:0];
        ptfm_pkg::REG_FLOW_GAIN:       gain_r     <= cfg_pwdata[ptfm_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_idx)
      ptfm_pkg::REG_REPORT_INTERVAL: cfg_prdata = ptfm_pkg::CFG_DATA_W'(interval_r);
      ptfm_pkg::REG_CLOCK_MHZ:       cfg_prdata = ptfm_pkg::CFG_DATA_W'(clock_r);
      ptfm_pkg::REG_FLOW_GAIN:       cfg_prdata = ptfm_pkg::CFG_DATA_W'(gain_r);
      default:                       cfg_prdata = '0;
    endcase
  end

  ptfm_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .edge_req        (in_tdata[0]),
    .report_interval (interval_r),
    .q_full          (q_full),
    .push            (q_push),
    .push_job        (push_job)
  );

  ptfm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  ptfm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job        (pop_job),
    .q_empty    (q_empty),
    .pop        (q_pop),
    .clock_mhz  (clock_r),
    .flow_gain  (gain_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_period (res_period),
    .out_freq   (res_freq),
    .out_flow   (res_flow),
    .out_report (res_report),
    .out_sat    (res_sat)
  );

  assign out_tdata = {res_flow, res_freq, res_period};
  assign out_tuser = {res_sat, res_report};

  // never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("job pushed into full queue");

  // input stalls only for a full queue
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> q_full)
    else $error("input stalled without full queue");

  // a zero period always flags saturation
  a_zero_period_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[31:0] == '0)) |-> out_tuser[1])
    else $error("zero period without saturation flag");

endmodule

// ===== test/tb_period_to_flow_meter.sv =====
// ----------------------------------------------------------------------------
// tb_period_to_flow_meter: self-checking bench for the period to flow meter
// Streams edge words into the meter and predicts every reading in a small
// scoreboard that tracks the counter, the report count and the registers.
// Checks each reading field by field and runs several register settings,
// the extremes among them, with random gaps and stalls on both streams in all but one.
// ----------------------------------------------------------------------------
module tb_period_to_flow_meter;

  localparam int DRAIN_CYCLES = 64;    // back end latency plus margin
  localparam int STUCK_LIMIT  = 4000;  // cycles with no word moving
  localparam logic [ptfm_pkg::RES_W-1:0] ALL_ONES = '1;

  typedef struct packed {
    logic [ptfm_pkg::RES_W-1:0] period;
    logic [ptfm_pkg::RES_W-1:0] freq;
    logic [ptfm_pkg::RES_W-1:0] flow;
    logic                       report;
    logic                       sat;
  } reading_t;

  // --------------------------------------------------------------------------
  // predictor of the meter readings
  // --------------------------------------------------------------------------
  class flow_reading_board;
    logic [ptfm_pkg::INTERVAL_W-1:0] interval;
    logic [ptfm_pkg::CLK_W-1:0]      clock_mhz;
    logic [ptfm_pkg::GAIN_W-1:0]     gain;
    ptfm_pkg::phase_t                phase;
    logic [ptfm_pkg::COUNT_BITS-1:0] cycle_count;
    logic [ptfm_pkg::INTERVAL_W-1:0] report_count;
    logic [ptfm_pkg::COUNT_BITS-1:0] latched_period;
    reading_t                        due_readings[$];
    int errors, words, readings, n_sat, n_report;

    function new();
      interval       = ptfm_pkg::INTERVAL_RST;
      clock_mhz      = ptfm_pkg::CLOCK_RST;
      gain           = ptfm_pkg::GAIN_RST;
      phase          = ptfm_pkg::PH_WAITING;
      cycle_count    = '0;
      report_count   = '0;
      latched_period = '0;
      errors = 0; words = 0; readings = 0; n_sat = 0; n_report = 0;
    endfunction

    function void set_reg(input logic [1:0] idx,
                          input logic [ptfm_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        ptfm_pkg::REG_REPORT_INTERVAL: interval  = value[ptfm_pkg::INTERVAL_W-1:0];
        ptfm_pkg::REG_CLOCK_MHZ:       clock_mhz = value[ptfm_pkg::CLK_W-1:0];
        ptfm_pkg::REG_FLOW_GAIN:       gain      = value[ptfm_pkg::GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    // advance one counting cycle; queue a reading when the meter computes
    function void predict_word(input logic edge_req);
      logic            wrapped;
      logic [63:0]     dividend, divisor, quotient, gain_w, freq_w, flow_w;
      reading_t        r;
      words++;
      cycle_count = cycle_count + 1'b1;
      wrapped = (cycle_count[ptfm_pkg::TIMER_BITS-1:0] == '0);
      if (phase == ptfm_pkg::PH_COMPUTING) begin
        if (wrapped && report_count < interval) report_count++;
        r.sat = 1'b0;
        if (latched_period == '0) begin
          r.freq = ALL_ONES;
          r.sat  = 1'b1;
        end else begin
          dividend = 64'(clock_mhz);
          divisor  = 64'(latched_period);
          quotient = dividend / divisor;
          if (quotient > 64'(ALL_ONES)) begin
            r.freq = ALL_ONES;
            r.sat  = 1'b1;
          end else begin
            r.freq = quotient[ptfm_pkg::RES_W-1:0];
          end
        end
        gain_w = 64'(gain);
        freq_w = 64'(r.freq);
        flow_w = (gain_w * freq_w) >> ptfm_pkg::FRAC_BITS;
        if (flow_w > 64'(ALL_ONES)) begin
          r.flow = ALL_ONES;
          r.sat  = 1'b1;
        end else begin
          r.flow = flow_w[ptfm_pkg::RES_W-1:0];
        end
        r.period = latched_period;
        r.report = (report_count >= interval);
        if (r.report) report_count = '0;
        due_readings.push_back(r);
        phase = ptfm_pkg::PH_WAITING;
        return;
      end
      // arming edge restarts the count and drops this cycle's wrap bump
      if (phase == ptfm_pkg::PH_WAITING && edge_req) begin
        cycle_count = '0;
        phase = ptfm_pkg::PH_COUNTING;
        return;
      end
      if (wrapped && report_count < interval) report_count++;
      if (phase == ptfm_pkg::PH_COUNTING && edge_req) begin
        latched_period = cycle_count;
        phase = ptfm_pkg::PH_COMPUTING;
      end
    endfunction

    function void note_mismatch(input string what, input logic [ptfm_pkg::RES_W-1:0] want,
                                input logic [ptfm_pkg::RES_W-1:0] got);
      errors++;
      if (errors <= 40)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    endfunction

    // compare one reading with the oldest prediction
    function void check_reading(input reading_t got);
      reading_t want;
      if (due_readings.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: reading with none expected, period %0d freq %0d flow %0d",
                   $time, got.period, got.freq, got.flow);
        return;
      end
      want = due_readings.pop_front();
      readings++;
      if (want.sat) n_sat++;
      if (want.report) n_report++;
      if (got.period !== want.period) note_mismatch("period", want.period, got.period);
      if (got.freq !== want.freq) note_mismatch("frequency", want.freq, got.freq);
      if (got.flow !== want.flow) note_mismatch("flow", want.flow, got.flow);
      if (got.report !== want.report)
        note_mismatch("report", ptfm_pkg::RES_W'(want.report), ptfm_pkg::RES_W'(got.report));
      if (got.sat !== want.sat)
        note_mismatch("saturated", ptfm_pkg::RES_W'(want.sat), ptfm_pkg::RES_W'(got.sat));
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [7:0]                      in_tdata = '0;     // [0] edge_req
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [95:0]                     out_tdata;         // [31:0] period, [63:32] freq,
                                                      // [95:64] flow
  logic [1:0]                      out_tuser;         // [0] report, [1] saturated
  logic                            cfg_psel = 1'b0;
  logic                            cfg_penable = 1'b0;
  logic                            cfg_pwrite = 1'b0;
  logic [ptfm_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [ptfm_pkg::CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [ptfm_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  flow_reading_board board = new();
  bit steady = 1'b0;   // no gaps or stalls while set
  int settings = 1;
  int stall_left = 0;
  int stuck_cycles = 0;

  period_to_flow_meter DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata), .cfg_pready(cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side: random stalls, check each accepted word
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_reading({out_tdata[31:0], out_tdata[63:32], out_tdata[95:64],
                           out_tuser[0], out_tuser[1]});
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      int g;
      g = gap_len();
      stall_left <= (g > 0) ? g - 1 : 0;
      out_tready <= (g == 0);
    end
  end

  // watchdog: end the run when no word moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("timeout after %0d idle cycles", stuck_cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // send one counting-cycle word, after an optional gap
  task automatic send_word(input logic edge_req);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, edge_req};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.predict_word(edge_req);
  endtask

  task automatic cfg_write(input logic [1:0] idx,
                           input logic [ptfm_pkg::CFG_DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    board.set_reg(idx, value);
  endtask

  task automatic configure(input logic [ptfm_pkg::INTERVAL_W-1:0] interval,
                           input logic [ptfm_pkg::CLK_W-1:0] clock_mhz,
                           input logic [ptfm_pkg::GAIN_W-1:0] gain);
    cfg_write(ptfm_pkg::REG_REPORT_INTERVAL, ptfm_pkg::CFG_DATA_W'(interval));
    cfg_write(ptfm_pkg::REG_CLOCK_MHZ, ptfm_pkg::CFG_DATA_W'(clock_mhz));
    cfg_write(ptfm_pkg::REG_FLOW_GAIN, ptfm_pkg::CFG_DATA_W'(gain));
    settings++;
  endtask

  // finish any pending computation, drain all readings, let the back end rest
  task automatic settle();
    if (board.phase == ptfm_pkg::PH_COMPUTING) send_word(1'b0);
    in_tvalid <= 1'b0;
    while (board.due_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // shortest periods, an ignored edge while computing, idle waiting words
  task automatic directed_run();
    send_word(1'b0);
    send_word(1'b1);
    send_word(1'b1);
    send_word(1'b1);
    send_word(1'b1);
    repeat (3) send_word(1'b0);
    send_word(1'b1);
    send_word(1'b0);
    send_word(1'b0);
    send_word(1'b1);
    send_word(1'b1);
    send_word(1'b0);
  endtask

  // mostly clean measurements with random edge on the compute word, some noise
  task automatic random_run(input int n_words);
    int sent, hold, n;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(0, 9) < 7) begin
        hold = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                            : $urandom_range(0, 12);
        send_word(1'b1);
        repeat (hold) send_word(1'b0);
        send_word(1'b1);
        send_word(1'($urandom_range(0, 1)));
        sent += hold + 3;
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) send_word(1'($urandom_range(0, 1)));
        sent += n;
      end
    end
  endtask

  initial begin
    logic [63:0] rnd;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults
    directed_run();
    random_run(60);
    settle();
    random_run(60);
    settle();

    // zero interval, largest clock and gain: saturation, report on every reading
    configure('0, '1, '1);
    directed_run();
    random_run(50);
    settle();

    // interval of one with zero clock and gain
    configure(16'd1, '0, '0);
    directed_run();
    random_run(40);
    settle();

    // largest interval, smallest nonzero clock and gain
    configure('1, 40'd1, 24'd1);
    random_run(40);
    settle();

    // random full-range registers, no gaps or stalls
    steady = 1'b1;
    rnd = {$urandom(), $urandom()};
    configure(ptfm_pkg::INTERVAL_W'($urandom_range(0, 65535)), rnd[ptfm_pkg::CLK_W-1:0],
              ptfm_pkg::GAIN_W'($urandom_range(0, 24'hFF_FFFF)));
    random_run(70);
    settle();
    steady = 1'b0;

    // random registers with a modest clock
    configure(ptfm_pkg::INTERVAL_W'($urandom_range(0, 8)),
              ptfm_pkg::CLK_W'($urandom_range(1, 5000000)),
              ptfm_pkg::GAIN_W'($urandom_range(0, 24'hFF_FFFF)));
    random_run(70);
    settle();

    $display("covered %0d input words and %0d readings (%0d saturated, %0d reported)",
             board.words, board.readings, board.n_sat, board.n_report);
    $display("across %0d register settings including zero and full-scale extremes",
             settings);
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== period_to_flow_meter.f =====
rtl/ptfm_pkg.sv
rtl/ptfm_queue.sv
rtl/ptfm_front.sv
rtl/ptfm_back.sv
rtl/period_to_flow_meter.sv
test/tb_period_to_flow_meter.sv
